@@ hw/rtl/ring_fifo_with_overwrite_top_macros.svh @@
// ----------------------------------------------------------------------------
// ring fifo assertion macros
// shared concurrent assertion forms for the ring fifo rtl
// ----------------------------------------------------------------------------
`ifndef RING_FIFO_WITH_OVERWRITE_TOP_MACROS_SVH
`define RING_FIFO_WITH_OVERWRITE_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define RF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle
`define RF_ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// consequence holds in the next cycle
`define RF_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ hw/rtl/rfifo_pkg.sv @@
// ----------------------------------------------------------------------------
// rfifo_pkg
// types, constants and helpers shared by the ring fifo modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfifo_pkg;

    localparam int DEPTH      = 16;
    localparam int WIDTH      = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_USED_CAPACITY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE     = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_PEEK  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        mode_t              mode;
        logic [WIDTH-1:0]   data_in;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [WIDTH-1:0]   data_out;
        logic [CNT_W-1:0]   fill_count;
        logic               is_empty;
        logic               is_full;
    } result_t;

    typedef struct packed {
        logic accept;
        logic execute;
        logic cfg_write;
    } ctrl_cmd_t;

    // capacity clamped into 1..DEPTH
    function automatic logic [CNT_W-1:0] eff_capacity(input logic [CFG_DATA_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if (32'(v) > DEPTH)
            r = CNT_W'(DEPTH);
        else
            r = CNT_W'(v);
        return r;
    endfunction

    // step an index with wrap at the capacity
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] n;
        n = CNT_W'(idx) + CNT_W'(1);
        return (n >= cap) ? '0 : n[PTR_W-1:0];
    endfunction

endpackage

@@ hw/rtl/rfifo_ctrl.sv @@
// ----------------------------------------------------------------------------
// rfifo_ctrl
// sequencer: accepts a command, runs the update cycle, strobes the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfifo_ctrl
    import rfifo_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    output ctrl_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_EXEC);
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign cfg_ready     = (state_reg == ST_IDLE);
    assign done          = done_reg;
    assign cmd.accept    = start && (state_reg == ST_IDLE);
    assign cmd.execute   = (state_reg == ST_EXEC);
    assign cmd.cfg_write = cfg_valid && (state_reg == ST_IDLE);

endmodule

@@ hw/rtl/rfifo_dp.sv @@
// ----------------------------------------------------------------------------
// rfifo_dp
// pointers, count, configuration and entry store of the ring fifo
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ring_fifo_with_overwrite_top_macros.svh"

module rfifo_dp
    import rfifo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    input  item_t                 item,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output result_t               result
);

    logic [WIDTH-1:0] mem [DEPTH];

    logic [CNT_W-1:0] cap_reg;
    logic             ovw_reg;
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;
    mode_t            op_mode_reg;
    logic [WIDTH-1:0] op_data_reg;
    logic [WIDTH-1:0] rd_data_reg;
    result_t          res_reg;

    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_next;
    result_t          res_next;
    logic             wr_en;
    logic             out_of_range;
    logic [PTR_W-1:0] rd_addr;
    logic             full;
    logic             empty;

    // indices outside the used region restart the queue
    assign out_of_range = (CNT_W'(head_reg) >= cap_reg) || (CNT_W'(tail_reg) >= cap_reg)
                          || (count_reg > cap_reg);
    assign rd_addr      = out_of_range ? '0 : head_reg;
    assign full         = (count_reg == cap_reg);
    assign empty        = (count_reg == '0);

    always_comb
    begin
        head_next           = head_reg;
        tail_next           = tail_reg;
        count_next          = count_reg;
        wr_en               = 1'b0;
        res_next.status     = STATUS_OK;
        res_next.data_out   = '0;
        unique case (op_mode_reg)
            MODE_PUSH:
            begin
                if (full && !ovw_reg)
                    res_next.status = STATUS_FULL;
                else
                begin
                    wr_en     = 1'b1;
                    tail_next = advance(tail_reg, cap_reg);
                    // full with overwrite: oldest word drops, count stays
                    if (full)
                        head_next = advance(head_reg, cap_reg);
                    else
                        count_next = count_reg + CNT_W'(1);
                end
            end
            MODE_POP:
            begin
                if (empty)
                    res_next.status = STATUS_EMPTY;
                else
                begin
                    res_next.data_out = rd_data_reg;
                    head_next         = advance(head_reg, cap_reg);
                    count_next        = count_reg - CNT_W'(1);
                end
            end
            MODE_PEEK:
            begin
                if (empty)
                    res_next.status = STATUS_EMPTY;
                else
                    res_next.data_out = rd_data_reg;
            end
            MODE_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
        res_next.fill_count = count_next;
        res_next.is_empty   = (count_next == '0);
        res_next.is_full    = (count_next == cap_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CNT_W'(DEPTH);
            ovw_reg   <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.cfg_write)
            begin
                if (cfg_index == CFG_USED_CAPACITY)
                begin
                    cap_reg   <= eff_capacity(cfg_data);
                    head_reg  <= '0;
                    tail_reg  <= '0;
                    count_reg <= '0;
                end
                else if (cfg_index == CFG_OVERWRITE)
                begin
                    ovw_reg   <= cfg_data[0];
                    head_reg  <= '0;
                    tail_reg  <= '0;
                    count_reg <= '0;
                end
            end
            else if (cmd.accept)
            begin
                if (out_of_range)
                begin
                    head_reg  <= '0;
                    tail_reg  <= '0;
                    count_reg <= '0;
                end
            end
            else if (cmd.execute)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    // operation word and registered read of the oldest entry
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_mode_reg <= item.mode;
            op_data_reg <= item.data_in;
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.execute)
            res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && wr_en)
            mem[tail_reg] <= op_data_reg;
    end

    assign result = res_reg;

    `RF_ASSERT_ALWAYS(a_count_le_cap, clk, rst_n, count_reg <= cap_reg,
                      "count above capacity")
    `RF_ASSERT_ALWAYS(a_head_in_cap, clk, rst_n, CNT_W'(head_reg) < cap_reg,
                      "head outside capacity")
    `RF_ASSERT_IMPLY(a_wr_not_refused, clk, rst_n, cmd.execute && wr_en,
                     !(full && !ovw_reg), "write on refused push")
    `RF_ASSERT_NEXT(a_refused_push, clk, rst_n,
                    cmd.execute && op_mode_reg == MODE_PUSH && full && !ovw_reg,
                    res_reg.status == STATUS_FULL && $stable(count_reg),
                    "full push not refused")

endmodule

@@ hw/rtl/ring_fifo_with_overwrite_top.sv @@
// ----------------------------------------------------------------------------
// ring_fifo_with_overwrite_top
// circular fifo of 32-bit words with optional overwrite of the oldest word
// ----------------------------------------------------------------------------
// Each command (push, pop, peek, clear) has an accept and an execute step:
// start is taken while busy is low, the accept step reads the oldest entry
// from the store into a register, the execute step updates pointers and count
// and writes the store. The result is driven for exactly one cycle with done
// high, in the cycle in which busy drops, and the receiver cannot stall it;
// a new command may be started in that same cycle, and none is taken while
// busy is high. Configuration writes are taken while busy is low; writes to
// the capacity or overwrite register clear the queue.
`timescale 1ns / 1ps

module ring_fifo_with_overwrite_top
    import rfifo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  item_t                 item,
    output logic                  done,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;

    rfifo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .done      (done),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    rfifo_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule

@@ sim/ring_fifo_with_overwrite_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_fifo_with_overwrite_top_test
// drives push, pop, peek and clear commands into the ring fifo with several
// capacity and overwrite settings. A directed table comes first, then random
// fill and drain bursts. Every reply is checked against the table or a shadow fifo.
// ----------------------------------------------------------------------------

module ring_fifo_with_overwrite_top_test;
    import rfifo_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 138;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_3 = CFG_IDX_W'(3);

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        item_t                 cmd;
        logic                  typed;
        result_t               want;
    } script_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    logic                  done;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // shadow fifo
    logic [WIDTH-1:0]      ring_words [DEPTH];
    logic [PTR_W-1:0]      ring_head    = '0;
    logic [PTR_W-1:0]      ring_tail    = '0;
    logic [CNT_W-1:0]      ring_count   = '0;
    logic [CFG_DATA_W-1:0] cap_setting  = CFG_DATA_W'(16);
    logic                  overwrite_en = 1'b0;

    result_t               owed_replies [$];
    result_t               oldest_reply;
    script_row_t           script [$];
    int                    errors    = 0;
    int                    cycle_cnt = 0;
    bit                    gaps_on   = 1'b1;

    ring_fifo_with_overwrite_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic void ring_reset();
        ring_head  = '0;
        ring_tail  = '0;
        ring_count = '0;
    endfunction

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx,
                                                   input int lim);
        return (int'(idx) + 1 >= lim) ? '0 : PTR_W'(int'(idx) + 1);
    endfunction

    function automatic result_t fifo_apply_cmd(input item_t cmd);
        result_t r;
        int      lim;
        lim = (cap_setting == '0) ? 1 :
              ((cap_setting > DEPTH) ? DEPTH : int'(cap_setting));
        r = '0;
        r.status = STATUS_OK;
        // indices outside the used region restart the queue
        if (ring_head >= lim || ring_tail >= lim || ring_count > lim)
            ring_reset();
        case (cmd.mode)
            MODE_PUSH:
            begin
                if (ring_count == lim && !overwrite_en)
                    r.status = STATUS_FULL;
                else
                begin
                    if (ring_count == lim)
                    begin
                        ring_head  = ring_next(ring_head, lim);
                        ring_count = ring_count - 1'b1;
                    end
                    ring_words[ring_tail] = cmd.data_in;
                    ring_tail  = ring_next(ring_tail, lim);
                    ring_count = ring_count + 1'b1;
                end
            end
            MODE_POP, MODE_PEEK:
            begin
                if (ring_count == '0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    r.data_out = ring_words[ring_head];
                    if (cmd.mode == MODE_POP)
                    begin
                        ring_head  = ring_next(ring_head, lim);
                        ring_count = ring_count - 1'b1;
                    end
                end
            end
            default:
                ring_reset();
        endcase
        r.fill_count = ring_count;
        r.is_empty   = (ring_count == '0);
        r.is_full    = (ring_count == lim);
        return r;
    endfunction

    function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] val);
        script_row_t row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic script_row_t cmd_row(input mode_t m, input logic [WIDTH-1:0] d);
        script_row_t row;
        row = '0;
        row.cmd.mode    = m;
        row.cmd.data_in = d;
        return row;
    endfunction

    function automatic script_row_t chk_row(input mode_t m, input logic [WIDTH-1:0] d,
                                            input status_t st, input logic [WIDTH-1:0] q,
                                            input int cnt, input logic emp,
                                            input logic ful);
        script_row_t row;
        row = cmd_row(m, d);
        row.typed           = 1'b1;
        row.want.status     = st;
        row.want.data_out   = q;
        row.want.fill_count = CNT_W'(cnt);
        row.want.is_empty   = emp;
        row.want.is_full    = ful;
        return row;
    endfunction

    // hold off until every reply is in and the block has settled
    task automatic wait_idle();
        start <= 1'b0;
        while (owed_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        while (gaps_on && $urandom_range(0, 99) < 7)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_USED_CAPACITY)
        begin
            cap_setting = val;
            ring_reset();
        end
        else if (idx == CFG_OVERWRITE)
        begin
            overwrite_en = val[0];
            ring_reset();
        end
    endtask

    task automatic issue_cmd(input item_t cmd, input logic typed, input result_t want);
        result_t predicted;
        while (gaps_on && $urandom_range(0, 99) < 7)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // word taken at this edge
        predicted = fifo_apply_cmd(cmd);
        owed_replies.push_back(typed ? want : predicted);
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (owed_replies.size() == 0)
            begin
                errors++;
                $display("%0t: reply with nothing owed: expected none, actual %h",
                         $time, result);
            end
            else
            begin
                oldest_reply = owed_replies.pop_front();
                if (result.status !== oldest_reply.status)
                begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, oldest_reply.status, result.status);
                end
                if (result.data_out !== oldest_reply.data_out)
                begin
                    errors++;
                    $display("%0t: data_out mismatch: expected %h, actual %h",
                             $time, oldest_reply.data_out, result.data_out);
                end
                if (result.fill_count !== oldest_reply.fill_count)
                begin
                    errors++;
                    $display("%0t: fill_count mismatch: expected %0d, actual %0d",
                             $time, oldest_reply.fill_count, result.fill_count);
                end
                if (result.is_empty !== oldest_reply.is_empty)
                begin
                    errors++;
                    $display("%0t: is_empty mismatch: expected %b, actual %b",
                             $time, oldest_reply.is_empty, result.is_empty);
                end
                if (result.is_full !== oldest_reply.is_full)
                begin
                    errors++;
                    $display("%0t: is_full mismatch: expected %b, actual %b",
                             $time, oldest_reply.is_full, result.is_full);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies owed",
                     cycle_cnt, owed_replies.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        script_row_t           row;
        item_t                 cmd;
        int                    roll;
        int                    push_share;
        logic [CFG_DATA_W-1:0] cap_pick;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;

        // empty reads, extremes of the data word, clear
        script.push_back(chk_row(MODE_POP,   32'h0, STATUS_EMPTY, 32'h0, 0, 1'b1, 1'b0));
        script.push_back(chk_row(MODE_PEEK,  32'hDEADBEEF, STATUS_EMPTY, 32'h0, 0, 1'b1, 1'b0));
        script.push_back(chk_row(MODE_PUSH,  32'hFFFFFFFF, STATUS_OK, 32'h0, 1, 1'b0, 1'b0));
        script.push_back(chk_row(MODE_PUSH,  32'h00000000, STATUS_OK, 32'h0, 2, 1'b0, 1'b0));
        script.push_back(chk_row(MODE_PEEK,  32'h0, STATUS_OK, 32'hFFFFFFFF, 2, 1'b0, 1'b0));
        script.push_back(chk_row(MODE_POP,   32'hFFFFFFFF, STATUS_OK, 32'hFFFFFFFF, 1, 1'b0, 1'b0));
        script.push_back(chk_row(MODE_CLEAR, 32'hFFFFFFFF, STATUS_OK, 32'h0, 0, 1'b1, 1'b0));
        // capacity of one, full push refused
        script.push_back(reg_row(CFG_USED_CAPACITY, CFG_DATA_W'(1)));
        script.push_back(chk_row(MODE_PUSH,  32'hA5A5A5A5, STATUS_OK, 32'h0, 1, 1'b0, 1'b1));
        script.push_back(chk_row(MODE_PUSH,  32'h5A5A5A5A, STATUS_FULL, 32'h0, 1, 1'b0, 1'b1));
        script.push_back(chk_row(MODE_POP,   32'h0, STATUS_OK, 32'hA5A5A5A5, 0, 1'b1, 1'b0));
        // overwrite on full, upper data bits ignored
        script.push_back(reg_row(CFG_OVERWRITE, CFG_DATA_W'(31)));
        script.push_back(chk_row(MODE_PUSH,  32'h12345678, STATUS_OK, 32'h0, 1, 1'b0, 1'b1));
        script.push_back(chk_row(MODE_PUSH,  32'h9ABCDEF0, STATUS_OK, 32'h0, 1, 1'b0, 1'b1));
        script.push_back(chk_row(MODE_PEEK,  32'h0, STATUS_OK, 32'h9ABCDEF0, 1, 1'b0, 1'b1));
        // zero capacity acts as one
        script.push_back(reg_row(CFG_USED_CAPACITY, CFG_DATA_W'(0)));
        script.push_back(chk_row(MODE_PUSH,  32'h00000001, STATUS_OK, 32'h0, 1, 1'b0, 1'b1));
        script.push_back(chk_row(MODE_PUSH,  32'h80000000, STATUS_OK, 32'h0, 1, 1'b0, 1'b1));
        script.push_back(chk_row(MODE_POP,   32'h0, STATUS_OK, 32'h80000000, 0, 1'b1, 1'b0));
        // capacity above depth acts as depth; unknown indexes leave the queue alone
        script.push_back(reg_row(CFG_USED_CAPACITY, CFG_DATA_W'(31)));
        script.push_back(cmd_row(MODE_PUSH,  32'h0F0F0F0F));
        script.push_back(cmd_row(MODE_PUSH,  32'hF0F0F0F0));
        script.push_back(cmd_row(MODE_PUSH,  32'h3C3C3C3C));
        script.push_back(reg_row(CFG_NO_REG_3, CFG_DATA_W'(31)));
        script.push_back(reg_row(CFG_NO_REG_2, CFG_DATA_W'(10)));
        script.push_back(cmd_row(MODE_POP,   32'h0));
        script.push_back(cmd_row(MODE_CLEAR, 32'h0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            row = script[i];
            if (row.is_cfg)
                write_reg(row.reg_idx, row.reg_val);
            else
                issue_cmd(row.cmd, row.typed, row.want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0:       cap_pick = CFG_DATA_W'($urandom_range(1, 4));
                1:       cap_pick = CFG_DATA_W'(DEPTH);
                2:       cap_pick = CFG_DATA_W'($urandom_range(0, 31));
                default: cap_pick = CFG_DATA_W'($urandom_range(5, 15));
            endcase
            write_reg(CFG_USED_CAPACITY, cap_pick);
            write_reg(CFG_OVERWRITE,
                      {CFG_DATA_W'($urandom_range(0, 15)) << 1} | CFG_DATA_W'((ph / 4) % 2));
            // one phase runs back to back with no gaps
            gaps_on = (ph != 5);
            push_share = 40;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // switch at random between filling and draining bursts
                if (n % 16 == 0)
                    push_share = $urandom_range(0, 1) ? 57 : 25;
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    cmd.mode = MODE_CLEAR;
                else if (roll < 18)
                    cmd.mode = MODE_PEEK;
                else if (roll < 18 + push_share)
                    cmd.mode = MODE_PUSH;
                else
                    cmd.mode = MODE_POP;
                cmd.data_in = $urandom();
                issue_cmd(cmd, 1'b0, '0);
            end
        end
        gaps_on = 1'b1;

        start <= 1'b0;
        while (owed_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES * 4) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/rfifo_pkg.sv
hw/rtl/rfifo_ctrl.sv
hw/rtl/rfifo_dp.sv
hw/rtl/ring_fifo_with_overwrite_top.sv
sim/ring_fifo_with_overwrite_top_test.sv
